>>> hdl/vfp_pkg.sv
// Package for the video frame pacer: field widths, action and mode codes,
// register indexes and the command and status bundles between control and datapath.
// No dependencies.
package vfp_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TAG_BITS_DEF    = 32;

    localparam int ACT_W     = 2;
    localparam int DELTA_W   = 24;
    localparam int TAG_W     = 32;
    localparam int MODE_W    = 2;
    localparam int FT_W      = 24;
    localparam int ACC_W     = 25;
    localparam int DUE_W     = 20;
    localparam int PLAYED_W  = 32;
    localparam int IN_W      = 64;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 24;

    localparam logic [FT_W-1:0]  FT_RESET = 24'd33333;
    localparam logic [DUE_W-1:0] DUE_MAX  = 20'hFFFFF;

    localparam logic [ACT_W-1:0] ACT_TICK = 2'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH = 2'd1;
    localparam logic [ACT_W-1:0] ACT_MODE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_STOPPED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PAUSED  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PLAYING = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HAS_VIDEO  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TIME = 1'd1;

    typedef struct packed {
        logic cap_in;
        logic exec_push;
        logic exec_mode;
        logic div_start;
        logic acc_update;
        logic drain;
        logic load_tag;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             has_video;
        logic             playing;
        logic             div_busy;
        logic             drain_shows;
        logic             out_free;
    } stat_t;

endpackage

>>> hdl/vfp_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module vfp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/vfp_div.sv
// Restoring divider for the pacer, one quotient bit per cycle.
// Depends on vfp_pkg for the dividend and divisor widths.
module vfp_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [vfp_pkg::ACC_W-1:0]  dividend,
    input  logic [vfp_pkg::FT_W-1:0]   divisor,
    output logic                       busy,
    output logic [vfp_pkg::ACC_W-1:0]  quotient,
    output logic [vfp_pkg::FT_W-1:0]   remainder
);

    localparam int CNT_W = $clog2(vfp_pkg::ACC_W);

    logic                      busy_reg, busy_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [vfp_pkg::ACC_W-1:0] quo_reg, quo_next;
    logic [vfp_pkg::FT_W-1:0]  rem_reg, rem_next;
    logic [vfp_pkg::ACC_W-1:0] trial;
    logic                      fits;

    assign trial = {rem_reg, quo_reg[vfp_pkg::ACC_W-1]};
    assign fits  = trial >= vfp_pkg::ACC_W'(divisor);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(vfp_pkg::ACC_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[vfp_pkg::ACC_W-2:0], fits};
            rem_next = fits ? vfp_pkg::FT_W'(trial - vfp_pkg::ACC_W'(divisor))
                            : vfp_pkg::FT_W'(trial);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> hdl/vfp_dp.sv
// Datapath of the pacer: configuration, pacing state, frame queue, divider and output register.
// Depends on vfp_pkg, vfp_ram and vfp_div.
module vfp_dp #(
    parameter int QUEUE_DEPTH = vfp_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = vfp_pkg::TAG_BITS_DEF,
    parameter int QW          = $clog2(QUEUE_DEPTH + 1),
    parameter int OUT_W       = ((67 + QW + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  vfp_pkg::cmd_t                 cmd,
    output vfp_pkg::stat_t                stat,
    input  logic                          cfg_we,
    input  logic [vfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vfp_pkg::CFG_W-1:0]     cfg_data,
    input  logic [vfp_pkg::IN_W-1:0]      in_data,
    input  logic [vfp_pkg::ACT_W-1:0]     in_user,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [OUT_W-1:0]              m_tdata
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = QW;
    localparam int SW = CW + 1;
    localparam int SUM_W = vfp_pkg::ACC_W + 1;

    function automatic logic [AW-1:0] wrap(input logic [SW-1:0] sum);
        if (sum >= SW'(QUEUE_DEPTH))
        begin
            return AW'(sum - SW'(QUEUE_DEPTH));
        end
        return AW'(sum);
    endfunction

    logic [vfp_pkg::ACT_W-1:0]   act_reg;
    logic [vfp_pkg::DELTA_W-1:0] delta_reg;
    logic [vfp_pkg::TAG_W-1:0]   tag_reg;
    logic [vfp_pkg::MODE_W-1:0]  mode_in_reg;

    logic                       has_video_reg;
    logic [vfp_pkg::FT_W-1:0]   ft_reg;

    logic [vfp_pkg::MODE_W-1:0]   play_reg, play_next;
    logic [vfp_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic [vfp_pkg::DUE_W-1:0]    due_reg, due_next;
    logic [vfp_pkg::PLAYED_W-1:0] played_reg, played_next;
    logic [vfp_pkg::TAG_W-1:0]    last_tag_reg, last_tag_next;
    logic                         last_valid_reg, last_valid_next;
    logic [AW-1:0]                head_reg, head_next;
    logic [CW-1:0]                count_reg, count_next;
    logic                         shown_reg, shown_next;
    logic                         refused_reg, refused_next;
    logic                         out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]             out_data_reg, out_data_next;

    logic [vfp_pkg::FT_W-1:0]  ft_eff;
    logic [vfp_pkg::ACC_W-1:0] dividend;
    logic                      div_busy;
    logic [vfp_pkg::ACC_W-1:0] quo;
    logic [vfp_pkg::FT_W-1:0]  rem;
    logic [SUM_W-1:0]          due_sum;
    logic                      full;
    logic                      ram_we;
    logic [AW-1:0]             waddr;
    logic [AW-1:0]             raddr;
    logic [TAG_BITS-1:0]       rdata;
    logic [CW-1:0]             n_drain;
    logic [vfp_pkg::DUE_W-1:0] due_after;
    logic [AW-1:0]             head_drain;

    assign ft_eff   = (ft_reg == '0) ? vfp_pkg::FT_W'(1) : ft_reg;
    assign dividend = acc_reg + vfp_pkg::ACC_W'(delta_reg);
    assign due_sum  = SUM_W'(due_reg) + SUM_W'(quo);
    assign full     = count_reg == CW'(QUEUE_DEPTH);
    assign ram_we   = cmd.exec_push && !full;
    assign waddr    = wrap(SW'(head_reg) + SW'(count_reg));

    assign n_drain    = (vfp_pkg::DUE_W'(count_reg) <= due_reg) ? count_reg : CW'(due_reg);
    assign due_after  = due_reg - vfp_pkg::DUE_W'(n_drain);
    assign raddr      = wrap(SW'(head_reg) + SW'(n_drain) - SW'(1));
    assign head_drain = wrap(SW'(head_reg) + SW'(n_drain));

    vfp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (dividend),
        .divisor   (ft_eff),
        .busy      (div_busy),
        .quotient  (quo),
        .remainder (rem)
    );

    vfp_ram #(
        .WIDTH (TAG_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (TAG_BITS'(tag_reg)),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.cap_in)
        begin
            act_reg     <= in_user;
            delta_reg   <= in_data[vfp_pkg::DELTA_W-1:0];
            tag_reg     <= in_data[55:24];
            mode_in_reg <= in_data[57:56];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_video_reg <= 1'b0;
            ft_reg        <= vfp_pkg::FT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vfp_pkg::CFG_HAS_VIDEO:  has_video_reg <= cfg_data[0];
                vfp_pkg::CFG_FRAME_TIME: ft_reg        <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        play_next       = play_reg;
        acc_next        = acc_reg;
        due_next        = due_reg;
        played_next     = played_reg;
        last_tag_next   = last_tag_reg;
        last_valid_next = last_valid_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        shown_next      = shown_reg;
        refused_next    = refused_reg;
        out_valid_next  = m_tready ? 1'b0 : out_valid_reg;
        out_data_next   = out_data_reg;

        if (cmd.cap_in)
        begin
            shown_next   = 1'b0;
            refused_next = 1'b0;
        end

        if (cmd.exec_push)
        begin
            if (full)
            begin
                refused_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end

        if (cmd.exec_mode && mode_in_reg <= vfp_pkg::MODE_PLAYING)
        begin
            if (mode_in_reg == vfp_pkg::MODE_PLAYING && play_reg == vfp_pkg::MODE_STOPPED)
            begin
                due_next    = vfp_pkg::DUE_W'(1);
                played_next = '0;
            end
            else if (mode_in_reg == vfp_pkg::MODE_STOPPED)
            begin
                due_next    = '0;
                played_next = '0;
                head_next   = '0;
                count_next  = '0;
            end
            play_next = mode_in_reg;
        end

        if (cmd.acc_update)
        begin
            acc_next = vfp_pkg::ACC_W'(rem);
            due_next = (due_sum > SUM_W'(vfp_pkg::DUE_MAX)) ? vfp_pkg::DUE_MAX
                                                          : vfp_pkg::DUE_W'(due_sum);
        end

        if (cmd.drain)
        begin
            due_next    = due_after;
            played_next = played_reg + vfp_pkg::PLAYED_W'(n_drain);
            head_next   = head_drain;
            count_next  = count_reg - n_drain;
        end

        if (cmd.load_tag)
        begin
            last_tag_next   = vfp_pkg::TAG_W'(rdata);
            last_valid_next = 1'b1;
            shown_next      = 1'b1;
        end

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = OUT_W'({refused_reg, count_reg, last_tag_reg,
                                     last_valid_reg, shown_reg, played_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            play_reg       <= vfp_pkg::MODE_STOPPED;
            acc_reg        <= '0;
            due_reg        <= '0;
            played_reg     <= '0;
            last_tag_reg   <= '0;
            last_valid_reg <= 1'b0;
            head_reg       <= '0;
            count_reg      <= '0;
            shown_reg      <= 1'b0;
            refused_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            play_reg       <= play_next;
            acc_reg        <= acc_next;
            due_reg        <= due_next;
            played_reg     <= played_next;
            last_tag_reg   <= last_tag_next;
            last_valid_reg <= last_valid_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            shown_reg      <= shown_next;
            refused_reg    <= refused_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign stat.act         = act_reg;
    assign stat.has_video   = has_video_reg;
    assign stat.playing     = play_reg == vfp_pkg::MODE_PLAYING;
    assign stat.div_busy    = div_busy;
    assign stat.drain_shows = (n_drain != '0) && (due_after == '0);
    assign stat.out_free    = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> hdl/vfp_ctrl.sv
// Controller of the pacer: sequences one request through the datapath.
// Depends on vfp_pkg for the command and status bundles.
module vfp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  vfp_pkg::stat_t stat,
    output vfp_pkg::cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EXEC  = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_ACCUM = 7'b0001000,
        S_DRAIN = 7'b0010000,
        S_LOAD  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap_in = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                case (stat.act)
                    vfp_pkg::ACT_TICK:
                    begin
                        if (stat.has_video && stat.playing)
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = S_DIV;
                        end
                        else if (stat.has_video)
                        begin
                            state_next = S_DRAIN;
                        end
                    end
                    vfp_pkg::ACT_PUSH: cmd.exec_push = 1'b1;
                    vfp_pkg::ACT_MODE: cmd.exec_mode = 1'b1;
                    default: ;
                endcase
            end
            S_DIV:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_ACCUM;
                end
            end
            S_ACCUM:
            begin
                cmd.acc_update = 1'b1;
                state_next     = S_DRAIN;
            end
            S_DRAIN:
            begin
                cmd.drain  = 1'b1;
                state_next = stat.drain_shows ? S_LOAD : S_DONE;
            end
            S_LOAD:
            begin
                cmd.load_tag = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = state_reg == S_IDLE;

endmodule

>>> hdl/video_frame_pacer.sv
// Top level of the video frame pacer: controller and datapath.
// Depends on vfp_pkg, vfp_ctrl and vfp_dp.
//
// Each request on the slave stream is a tick, a frame push or a playback mode change,
// selected by s_tuser. Each request gives exactly one result on the master stream.
// Configuration registers are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while no request is in flight, and the block does not enforce this.
// A push, a mode change, an unknown action or a tick without video goes from the execute
// state straight to the done state, which loads the result and frees the input together.
// A tick while playing runs the bit-serial divider, updates the accumulator, drains the queue
// in one step and, when a frame is shown, reads the shown tag from the queue memory.
// A tick with video while paused or stopped skips the divider and goes to the drain step.
// The result sits in an output register, so a new request is accepted while the
// previous result waits; if the receiver still stalls when the next result is ready,
// the controller holds it and accepts nothing further until the register frees.
// Reset clears all pacing state and sets the configuration to its defaults; queue contents
// need no clearing since only counted entries are ever read.
module video_frame_pacer #(
    parameter int QUEUE_DEPTH = vfp_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = vfp_pkg::TAG_BITS_DEF,
    parameter int QW          = $clog2(QUEUE_DEPTH + 1),
    parameter int OUT_W       = ((67 + QW + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [vfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vfp_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // delta_us, frame_tag, new_mode, zero fill
    input  logic [vfp_pkg::IN_W-1:0]      s_tdata,
    // action
    input  logic [vfp_pkg::ACT_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // played_count, frame_shown, shown_valid, shown_tag, queue_level, push_refused, zero fill
    output logic [OUT_W-1:0]              m_tdata
);

    vfp_pkg::cmd_t  cmd;
    vfp_pkg::stat_t stat;

    vfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    vfp_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS),
        .QW          (QW),
        .OUT_W       (OUT_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .in_user   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

>>> hdl/vfp_checker.sv
// Port-level checker for the video frame pacer, bound to the top level.
// Depends on vfp_pkg for the default queue depth.
module vfp_checker #(
    parameter int QUEUE_DEPTH = vfp_pkg::QUEUE_DEPTH_DEF,
    parameter int QW          = $clog2(QUEUE_DEPTH + 1),
    parameter int OUT_W       = ((67 + QW + 7) / 8) * 8
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    logic [QW-1:0] level;

    assign level = m_tdata[QW+65:66];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("Result withdrawn while stalled.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Request accepted while another is in progress.");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> level <= QW'(QUEUE_DEPTH))
        else $error("Queue level beyond depth.");

    a_shown_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[32] |-> m_tdata[33])
        else $error("Frame shown without a valid shown tag.");

    a_refused_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[QW+66] |-> level == QW'(QUEUE_DEPTH))
        else $error("Push refused while the queue had room.");

endmodule

bind video_frame_pacer vfp_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .QW          (QW),
    .OUT_W       (OUT_W)
) u_vfp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
